// File: rtl/dltq_pkg.sv
package dltq_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int ID_BITS = 8;

    typedef enum logic [2:0] {
        MODE_TICK     = 3'd0,
        MODE_ADD      = 3'd1,
        MODE_REMOVE   = 3'd2,
        MODE_DISPATCH = 3'd3,
        MODE_CLEAR    = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_NONE     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_INS_SCAN,
        S_INS_SHIFT,
        S_INS_WRITE,
        S_INS_FIX,
        S_REM_SCAN,
        S_REM_FIX,
        S_REM_SHIFT,
        S_REINSERT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic tick_dec;
        logic tick_ready;
        logic clear;
        logic scan_start;
        logic scan_step;
        logic ins_shift;
        logic ins_write;
        logic ins_fix;
        logic rem_fix;
        logic rem_shift;
        logic reinsert_load;
        logic set_status;
        status_t status;
        logic set_ran;
    } dltq_cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic empty;
        logic full;
        logic head_zero;
        logic head_ready;
        logic add_front;
        logic scan_end;
        logic scan_hit;
        logic shift_end;
        logic reinsert;
    } dltq_stat_t;

endpackage

// File: rtl/dltq_datapath.sv
module dltq_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [2:0]           in_mode,
    input  logic [7:0]           in_task_id,
    input  logic [31:0]          in_delay,
    input  logic [31:0]          in_period,
    input  dltq_pkg::dltq_cmd_t  cmd,
    output dltq_pkg::dltq_stat_t stat,
    output logic [1:0]           out_status,
    output logic                 out_ran,
    output logic [7:0]           out_task_id,
    output logic [4:0]           out_task_count
);
    import dltq_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [ID_BITS-1:0] id_mem [MAX_ENTRIES];
    logic [31:0]        delta_mem [MAX_ENTRIES];
    logic [31:0]        period_mem [MAX_ENTRIES];

    logic [CW-1:0]      count_reg;
    logic               ready_reg;
    logic [2:0]         mode_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [31:0]        delay_reg;
    logic [31:0]        period_reg;
    logic [CW-1:0]      pos_reg;
    logic [32:0]        sum_reg;
    logic [32:0]        before_reg;
    logic [31:0]        nd_reg;
    logic [1:0]         status_reg;
    logic               ran_reg;
    logic [ID_BITS-1:0] hid_reg;

    logic [IW-1:0] pos_idx, posp_idx, posm_idx;
    logic [32:0]   sum_next;
    logic [32:0]   sat_sum;
    logic          add_hit;

    assign pos_idx  = pos_reg[IW-1:0];
    assign posp_idx = IW'(pos_reg + CW'(1));
    assign posm_idx = IW'(pos_reg - CW'(1));
    assign sum_next = sum_reg + {1'b0, delta_mem[pos_idx]};
    assign sat_sum  = {1'b0, delta_mem[posp_idx]} + {1'b0, delta_mem[pos_idx]};
    assign add_hit  = ((pos_reg == '0) && stat.add_front) || (sum_next > {1'b0, delay_reg});

    assign stat.mode      = mode_reg;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg >= CW'(MAX_ENTRIES));
    assign stat.head_zero = (delta_mem[0] == 32'd0);
    assign stat.head_ready = ready_reg;
    assign stat.add_front = (count_reg == '0) || (delay_reg <= delta_mem[0]);
    assign stat.scan_end  = (pos_reg >= count_reg);
    assign stat.scan_hit  = (mode_reg == MODE_REMOVE) ? (id_mem[pos_idx] == id_reg)
                                                       : (sum_next > {1'b0, delay_reg});
    assign stat.shift_end = (mode_reg == MODE_ADD) ? (pos_reg == before_reg[CW-1:0])
                                                    : (pos_reg >= count_reg);
    assign stat.reinsert  = (period_reg != 32'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ready_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                count_reg <= '0;
                ready_reg <= 1'b0;
            end
            if (cmd.tick_ready) ready_reg <= 1'b1;
            if (cmd.ins_write) begin
                count_reg <= count_reg + CW'(1);
                if (pos_reg == '0) ready_reg <= 1'b0;
            end
            if (cmd.rem_fix) begin
                count_reg <= count_reg - CW'(1);
                if (pos_reg == '0) ready_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg   <= in_mode;
            id_reg     <= in_task_id[ID_BITS-1:0];
            delay_reg  <= in_delay;
            period_reg <= in_period;
            ran_reg    <= 1'b0;
            hid_reg    <= '0;
        end
        if (cmd.set_status) status_reg <= cmd.status;
        if (cmd.set_ran) begin
            ran_reg <= 1'b1;
            hid_reg <= id_mem[0];
            period_reg <= period_mem[0];
        end
        if (cmd.reinsert_load) begin
            mode_reg  <= MODE_ADD;
            id_reg    <= hid_reg;
            delay_reg <= period_reg;
        end
        if (cmd.tick_dec) delta_mem[0] <= delta_mem[0] - 32'd1;
        if (cmd.scan_start) begin
            pos_reg    <= '0;
            sum_reg    <= '0;
            before_reg <= '0;
        end
        if (cmd.scan_step) begin
            if (mode_reg == MODE_REMOVE) begin
                if (id_mem[pos_idx] != id_reg) pos_reg <= pos_reg + CW'(1);
            end else if (add_hit) begin
                // keep insert position in before_reg; latch target, start shift from tail
                nd_reg     <= 32'(33'(delay_reg) - before_reg);
                before_reg <= 33'(pos_reg);
                pos_reg    <= count_reg;
            end else if (pos_reg + CW'(1) >= count_reg) begin
                nd_reg     <= 32'(33'(delay_reg) - sum_next);
                before_reg <= 33'(count_reg);
                pos_reg    <= count_reg;
            end else begin
                before_reg <= sum_next;
                sum_reg    <= sum_next;
                pos_reg    <= pos_reg + CW'(1);
            end
        end
        if (cmd.ins_shift) begin
            id_mem[pos_idx]     <= id_mem[posm_idx];
            delta_mem[pos_idx]  <= delta_mem[posm_idx];
            period_mem[pos_idx] <= period_mem[posm_idx];
            pos_reg <= pos_reg - CW'(1);
        end
        if (cmd.ins_write) begin
            id_mem[pos_idx]     <= id_reg;
            delta_mem[pos_idx]  <= nd_reg;
            period_mem[pos_idx] <= period_reg;
        end
        if (cmd.ins_fix) begin
            if (pos_reg + CW'(1) < count_reg)
                delta_mem[posp_idx] <= (delta_mem[posp_idx] >= nd_reg) ?
                                       delta_mem[posp_idx] - nd_reg : 32'd0;
        end
        if (cmd.rem_fix) begin
            if (pos_reg + CW'(1) < count_reg)
                delta_mem[posp_idx] <= sat_sum[32] ? 32'hFFFF_FFFF : sat_sum[31:0];
        end
        if (cmd.rem_shift) begin
            id_mem[pos_idx]     <= id_mem[posp_idx];
            delta_mem[pos_idx]  <= delta_mem[posp_idx];
            period_mem[pos_idx] <= period_mem[posp_idx];
            pos_reg <= pos_reg + CW'(1);
        end
    end

    assign out_status     = status_reg;
    assign out_ran        = ran_reg;
    assign out_task_id    = 8'(hid_reg);
    assign out_task_count = 5'(count_reg);

endmodule

// File: rtl/dltq_ctrl.sv
module dltq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic                 out_fire,
    input  dltq_pkg::dltq_stat_t stat,
    output dltq_pkg::dltq_cmd_t  cmd,
    output logic                 in_ready,
    output logic                 out_valid,
    output logic                 add_ok
);
    import dltq_pkg::*;

    state_t state_reg, state_next;
    logic   redisp_reg, redisp_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            redisp_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            redisp_reg <= redisp_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        redisp_next = redisp_reg;
        cmd         = '0;
        cmd.status  = ST_OK;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        add_ok      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_fire) begin
                    cmd.load    = 1'b1;
                    redisp_next = 1'b0;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.set_status = 1'b1;
                state_next     = S_DONE;
                priority case (stat.mode)
                    MODE_TICK: begin
                        if (stat.empty) cmd.status = ST_NONE;
                        else if (stat.head_zero) cmd.tick_ready = 1'b1;
                        else cmd.tick_dec = 1'b1;
                    end
                    MODE_ADD: begin
                        if (stat.full) begin
                            cmd.status = ST_FULL;
                        end else begin
                            cmd.scan_start = 1'b1;
                            add_ok = !redisp_reg;
                            state_next = S_INS_SCAN;
                        end
                    end
                    MODE_REMOVE: begin
                        cmd.scan_start = 1'b1;
                        state_next = S_REM_SCAN;
                    end
                    MODE_DISPATCH: begin
                        if (stat.empty || !stat.head_ready) begin
                            cmd.status = ST_NONE;
                        end else begin
                            cmd.set_ran = 1'b1;
                            cmd.scan_start = 1'b1;
                            state_next = S_REM_FIX;
                        end
                    end
                    MODE_CLEAR: cmd.clear = 1'b1;
                    default: ;
                endcase
            end
            S_INS_SCAN: begin
                if (stat.add_front) begin
                    cmd.scan_step = 1'b1;
                    state_next = S_INS_SHIFT;
                end else if (stat.scan_end) begin
                    state_next = S_INS_SHIFT;
                end else begin
                    cmd.scan_step = 1'b1;
                    if (stat.scan_hit) state_next = S_INS_SHIFT;
                end
            end
            S_INS_SHIFT: begin
                if (stat.shift_end) state_next = S_INS_WRITE;
                else cmd.ins_shift = 1'b1;
            end
            S_INS_WRITE: begin
                cmd.ins_write = 1'b1;
                state_next = S_INS_FIX;
            end
            S_INS_FIX: begin
                cmd.ins_fix = 1'b1;
                state_next = S_DONE;
            end
            S_REM_SCAN: begin
                if (stat.scan_end) begin
                    cmd.set_status = 1'b1;
                    cmd.status = ST_NOTFOUND;
                    state_next = S_DONE;
                end else if (stat.scan_hit) begin
                    state_next = S_REM_FIX;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_REM_FIX: begin
                cmd.rem_fix = 1'b1;
                state_next = S_REM_SHIFT;
            end
            S_REM_SHIFT: begin
                if (stat.shift_end) begin
                    state_next = (stat.mode == MODE_DISPATCH) ? S_REINSERT : S_DONE;
                end else begin
                    cmd.rem_shift = 1'b1;
                end
            end
            S_REINSERT: begin
                if (stat.reinsert) begin
                    cmd.reinsert_load = 1'b1;
                    redisp_next = 1'b1;
                    state_next = S_DECIDE;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                out_valid = 1'b1;
                if (out_fire) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// File: rtl/delta_list_task_timer_queue.sv
// Delta-list timer queue: one request item in, one status item out. One item
// is in work at a time and the result holds until taken. Tick, clear, an add
// to a full table and the unused modes go from the decide state straight to
// the result. Every table walk moves one entry per cycle, so an add, a remove
// or a dispatch takes longer the more entries are queued, and a periodic
// dispatch removes the head and then runs a full insert pass.
module delta_list_task_timer_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // mode[2:0], task_id[10:3], delay[42:11], period[74:43]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[1:0], ran[2], out_task_id[10:3], task_count[15:11]
);
    import dltq_pkg::*;

    dltq_cmd_t  cmd;
    dltq_stat_t stat;
    logic       in_fire, out_fire, add_ok;
    logic [1:0] st;
    logic       ran;
    logic [7:0] oid;
    logic [4:0] cnt;
    logic [7:0] add_id_reg;
    logic       add_ok_reg;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    dltq_ctrl u_ctrl (
        .aclk, .aresetn, .in_fire, .out_fire, .stat, .cmd,
        .in_ready(s_tready), .out_valid(m_tvalid), .add_ok
    );

    dltq_datapath u_dp (
        .aclk, .aresetn,
        .in_mode(s_tdata[2:0]), .in_task_id(s_tdata[10:3]),
        .in_delay(s_tdata[42:11]), .in_period(s_tdata[74:43]),
        .cmd, .stat,
        .out_status(st), .out_ran(ran), .out_task_id(oid), .out_task_count(cnt)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            add_ok_reg <= 1'b0;
            add_id_reg <= 8'(s_tdata[3 +: ID_BITS]);
        end
        if (add_ok) add_ok_reg <= 1'b1;
    end

    assign m_tdata = {cnt, (add_ok_reg ? add_id_reg : oid), ran, st};

endmodule
